// File: rtl/vdr_pkg.sv
// Package for the vertex dedup/remap block: sizes, codes, entry types,
// coordinate compare and bucket hash. No dependencies.
package vdr_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int HBITS      = IDX_W + 1;
    localparam int EPOCH_W    = 4;
    localparam int COORD_W    = 32;
    localparam int KEY_W      = 3 * COORD_W;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_REMAP   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HRD,
        S_PRD,
        S_TRD
    } t_state;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   idx;
    } t_hash_entry;

    typedef struct packed {
        logic               re;
        logic [HBITS-1:0]   raddr;
        logic               we;
        logic [HBITS-1:0]   waddr;
        t_hash_entry        wdata;
    } t_hash_req;

    typedef struct packed {
        logic               p_re;
        logic [IDX_W-1:0]   p_raddr;
        logic               p_we;
        logic [IDX_W-1:0]   p_waddr;
        logic [KEY_W-1:0]   p_wdata;
        logic               t_re;
        logic [IDX_W-1:0]   t_raddr;
        logic               t_we;
        logic [IDX_W-1:0]   t_waddr;
        logic [IDX_W-1:0]   t_wdata;
    } t_store_req;

    function automatic logic is_nan(input logic [COORD_W-1:0] b);
        return b[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic coord_eq(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if ((a[30:0] | b[30:0]) == 31'd0) begin
            res = 1'b1;
        end else begin
            res = (a == b);
        end
        return res;
    endfunction

    function automatic logic key_eq(input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b);
        return coord_eq(a[31:0], b[31:0]) && coord_eq(a[63:32], b[63:32])
            && coord_eq(a[95:64], b[95:64]);
    endfunction

    function automatic logic [COORD_W-1:0] zero_norm(input logic [COORD_W-1:0] c);
        return (c[30:0] == 31'd0) ? '0 : c;
    endfunction

    function automatic logic [HBITS-1:0] bucket_hash(input logic [KEY_W-1:0] k);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] h;
        x = zero_norm(k[31:0]);
        y = zero_norm(k[63:32]);
        z = zero_norm(k[95:64]);
        h = x ^ {y[24:0], y[31:25]} ^ {z[18:0], z[31:19]};
        h = h ^ (h >> 11) ^ (h >> 22);
        return h[HBITS-1:0];
    endfunction

endpackage

// File: rtl/vertex_dedup_remap_core.sv
// Vertex dedup/remap top level: control sequencer, bucket table, point store.
// Depends on vdr_pkg, vdr_hash_table, vdr_point_store.
//
// Input words carry an op in tuser (load, remap, restart) and x/y/z/index
// in tdata. Every input word gives exactly one output word: new_index in
// tdata, first_seen and error in tuser.
// A load hashes the point into a 2048-bucket table and probes linearly;
// each probe reads a bucket and then the stored point. A load ends at a
// matching stored point or, for a new point, at the first empty bucket.
// The output register holds a result until taken; a stalled receiver
// holds s_tready low until its word leaves.
// Restart bumps the bucket epoch; after reset and whenever the epoch wraps
// (every 15th restart) a clearing pass sweeps all 2048 buckets
// of the table while s_tready stays low.
module vertex_dedup_remap_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,  // coord_x, coord_y, coord_z, orig_index, zero pad
    input  logic [1:0]   i_s_tuser,  // op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [15:0]  o_m_tdata,  // new_index, zero pad
    output logic [1:0]   o_m_tuser   // first_seen, error
);
    import vdr_pkg::*;

    t_state             r_state, n_state;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [CNT_W-1:0]   r_loaded, n_loaded;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [HBITS-1:0]   r_bucket, n_bucket;
    logic [HBITS-1:0]   r_clr, n_clr;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [IDX_W-1:0]   r_hidx, n_hidx;
    logic               r_ovalid, n_ovalid;
    logic [IDX_W-1:0]   r_onew, n_onew;
    logic               r_ofirst, n_ofirst;
    logic               r_oerr, n_oerr;

    t_hash_req          hreq;
    t_hash_entry        hdata;
    t_store_req         sreq;
    logic [KEY_W-1:0]   pdata;
    logic [IDX_W-1:0]   tdata;
    logic               accept;
    logic [KEY_W-1:0]   in_key;
    logic [IDX_W-1:0]   in_idx;
    logic [HBITS-1:0]   next_bucket;

    vdr_hash_table u_hash (
        .i_clk   (i_clk),
        .i_req   (hreq),
        .o_rdata (hdata)
    );

    vdr_point_store u_store (
        .i_clk   (i_clk),
        .i_req   (sreq),
        .o_point (pdata),
        .o_trans (tdata)
    );

    assign o_s_tready  = (r_state == S_IDLE) && !r_ovalid;
    assign accept      = i_s_tvalid && o_s_tready;
    assign in_key      = i_s_tdata[KEY_W-1:0];
    assign in_idx      = i_s_tdata[KEY_W+IDX_W-1:KEY_W];
    assign next_bucket = r_bucket + 1'b1;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(16-IDX_W){1'b0}}, r_onew};
    assign o_m_tuser  = {r_oerr, r_ofirst};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_epoch  <= EPOCH_W'(1);
            r_loaded <= '0;
            r_count  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_epoch  <= n_epoch;
            r_loaded <= n_loaded;
            r_count  <= n_count;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bucket <= n_bucket;
        r_key    <= n_key;
        r_hidx   <= n_hidx;
        r_onew   <= n_onew;
        r_ofirst <= n_ofirst;
        r_oerr   <= n_oerr;
    end

    always_comb begin
        n_state  = r_state;
        n_epoch  = r_epoch;
        n_loaded = r_loaded;
        n_count  = r_count;
        n_bucket = r_bucket;
        n_clr    = r_clr;
        n_key    = r_key;
        n_hidx   = r_hidx;
        n_ovalid = r_ovalid && !i_m_tready;
        n_onew   = r_onew;
        n_ofirst = r_ofirst;
        n_oerr   = r_oerr;
        hreq     = '0;
        sreq     = '0;

        case (r_state)
            S_CLR: begin
                hreq.we    = 1'b1;
                hreq.waddr = r_clr;
                hreq.wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_onew   = '0;
                    n_ofirst = 1'b0;
                    n_oerr   = 1'b0;
                    case (i_s_tuser)
                        OP_LOAD: begin
                            if (r_loaded == CNT_W'(MAX_POINTS)) begin
                                n_oerr   = 1'b1;
                                n_ovalid = 1'b1;
                            end else begin
                                n_key      = in_key;
                                n_bucket   = bucket_hash(in_key);
                                hreq.re    = 1'b1;
                                hreq.raddr = bucket_hash(in_key);
                                n_state    = S_HRD;
                            end
                        end
                        OP_REMAP: begin
                            if (CNT_W'(in_idx) >= r_loaded) begin
                                n_oerr   = 1'b1;
                                n_ovalid = 1'b1;
                            end else begin
                                sreq.t_re    = 1'b1;
                                sreq.t_raddr = in_idx;
                                n_state      = S_TRD;
                            end
                        end
                        OP_RESTART: begin
                            n_loaded = '0;
                            n_count  = '0;
                            n_ovalid = 1'b1;
                            if (r_epoch == EPOCH_LAST) begin
                                n_epoch = EPOCH_W'(1);
                                n_clr   = '0;
                                n_state = S_CLR;
                            end else begin
                                n_epoch = r_epoch + 1'b1;
                            end
                        end
                        default: begin
                            n_oerr   = 1'b1;
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            S_HRD: begin
                if (hdata.epoch != r_epoch) begin
                    hreq.we      = 1'b1;
                    hreq.waddr   = r_bucket;
                    hreq.wdata   = '{epoch: r_epoch, idx: r_count[IDX_W-1:0]};
                    sreq.p_we    = 1'b1;
                    sreq.p_waddr = r_count[IDX_W-1:0];
                    sreq.p_wdata = r_key;
                    sreq.t_we    = 1'b1;
                    sreq.t_waddr = r_loaded[IDX_W-1:0];
                    sreq.t_wdata = r_count[IDX_W-1:0];
                    n_onew       = r_count[IDX_W-1:0];
                    n_ofirst     = 1'b1;
                    n_ovalid     = 1'b1;
                    n_loaded     = r_loaded + 1'b1;
                    n_count      = r_count + 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_hidx       = hdata.idx;
                    sreq.p_re    = 1'b1;
                    sreq.p_raddr = hdata.idx;
                    n_state      = S_PRD;
                end
            end
            S_PRD: begin
                if (key_eq(pdata, r_key)) begin
                    sreq.t_we    = 1'b1;
                    sreq.t_waddr = r_loaded[IDX_W-1:0];
                    sreq.t_wdata = r_hidx;
                    n_onew       = r_hidx;
                    n_ovalid     = 1'b1;
                    n_loaded     = r_loaded + 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_bucket   = next_bucket;
                    hreq.re    = 1'b1;
                    hreq.raddr = next_bucket;
                    n_state    = S_HRD;
                end
            end
            S_TRD: begin
                n_onew   = tdata;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/vdr_hash_table.sv
// Bucket table of the point lookup: epoch-tagged distinct-point numbers.
// One write port, one registered read port. Uses vdr_pkg.
module vdr_hash_table (
    input  logic                 i_clk,
    input  vdr_pkg::t_hash_req   i_req,
    output vdr_pkg::t_hash_entry o_rdata
);
    import vdr_pkg::*;

    t_hash_entry r_mem [2**HBITS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

// File: rtl/vdr_point_store.sv
// Distinct point coordinates and load-order translation table.
// Two memories, each one write and one registered read port. Uses vdr_pkg.
module vdr_point_store (
    input  logic                          i_clk,
    input  vdr_pkg::t_store_req           i_req,
    output logic [vdr_pkg::KEY_W-1:0]     o_point,
    output logic [vdr_pkg::IDX_W-1:0]     o_trans
);
    import vdr_pkg::*;

    logic [KEY_W-1:0] r_points [MAX_POINTS];
    logic [IDX_W-1:0] r_trans  [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_req.p_we) begin
            r_points[i_req.p_waddr] <= i_req.p_wdata;
        end
        if (i_req.p_re) begin
            o_point <= r_points[i_req.p_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.t_we) begin
            r_trans[i_req.t_waddr] <= i_req.t_wdata;
        end
        if (i_req.t_re) begin
            o_trans <= r_trans[i_req.t_raddr];
        end
    end

endmodule

// File: rtl/vdr_checker.sv
// Port-level checks for vertex_dedup_remap_core, attached by bind.
// Uses vdr_pkg op codes and the top level's ports.
module vdr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [1:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [15:0]  o_m_tdata,
    input logic [1:0]   o_m_tuser
);
    import vdr_pkg::*;

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input taken while a result waits");

    a_first_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> !o_m_tuser[1])
        else $error("first_seen together with error");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_RESTART |=>
            o_m_tvalid && o_m_tdata == 16'd0 && o_m_tuser == 2'd0)
        else $error("restart result not all zero");

    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_UNUSED |=>
            o_m_tvalid && o_m_tdata == 16'd0 && o_m_tuser == 2'd2)
        else $error("unused op not answered with error");

endmodule

bind vertex_dedup_remap_core vdr_checker u_vdr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
